FILE: rtl/lmc_pkg.sv
package lmc_pkg;

   localparam int NUM_LETTERS_DEFAULT = 26;
   localparam int COUNT_WIDTH_DEFAULT = 8;
   localparam int TOTAL_WIDTH         = 16;
   localparam int RSP_FIFO_DEPTH      = 3;

   localparam logic [7:0] LOWEST_LETTER  = 8'h61;
   localparam logic [7:0] HIGHEST_LETTER = 8'h7A;
   localparam int         LETTER_SPAN    = int'(HIGHEST_LETTER) - int'(LOWEST_LETTER) + 1;

   localparam logic CMD_POOL      = 1'b0;
   localparam logic CMD_CANDIDATE = 1'b1;

   typedef struct packed {
      logic       cmd;
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic                   contained;
      logic [TOTAL_WIDTH-1:0] candidate_letters;
      logic [TOTAL_WIDTH-1:0] pool_letters;
   } rsp_type;

endpackage

FILE: rtl/lmc_result_fifo.sv
module lmc_result_fifo
   import lmc_pkg::*;
(
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wr_en,
   input  rsp_type                              wr_data,
   output logic                                 rd_valid,
   input  logic                                 rd_ready,
   output rsp_type                              rd_data,
   output logic [$clog2(RSP_FIFO_DEPTH+1)-1:0] count
);

   localparam int DEPTH = RSP_FIFO_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_type              mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff;
   logic [PTR_W-1:0]     wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff;
   logic [PTR_W-1:0]     rd_ptr_in;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic                 rd_fire;

   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign count    = count_ff;
   assign rd_fire  = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_fire) begin
         count_in = count_ff + 1'b1;
      end else if (!wr_en && rd_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_no_write_when_full: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> count_ff != CNT_W'(DEPTH))
      else $error("result queue written while full");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("result queue count out of range");

   a_read_drains: assert property (@(posedge clock) disable iff (reset)
      (rd_fire && !wr_en) |=> count_ff == $past(count_ff) - 1'b1)
      else $error("result queue count did not drop on read");

endmodule

FILE: rtl/letter_multiset_containment_core.sv
// channel | ports                          | transfer when
// req     | req_valid req_ready req_data   | req_valid && req_ready
// rsp     | rsp_valid rsp_ready rsp_data   | rsp_valid && rsp_ready
//
// one item per cycle while req_ready is high; an accepted item is registered, then all
// histogram lanes update and compare in parallel in the next cycle and a result enters
// the result queue. a three-entry result queue keeps req open while results wait;
// req_ready drops only when queued results plus the item in flight fill the queue.
// reset (synchronous) clears both histograms and totals and opens a new pool.
module letter_multiset_containment_core
   import lmc_pkg::*;
#(
   parameter int NUM_LETTERS = NUM_LETTERS_DEFAULT,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int CNT_W = $clog2(RSP_FIFO_DEPTH + 1);

   logic                   in_valid_ff;
   req_type                in_data_ff;
   logic [COUNT_WIDTH-1:0] pool_hist_ff [NUM_LETTERS];
   logic [COUNT_WIDTH-1:0] pool_hist_in [NUM_LETTERS];
   logic [COUNT_WIDTH-1:0] cand_hist_ff [NUM_LETTERS];
   logic [COUNT_WIDTH-1:0] cand_hist_in [NUM_LETTERS];
   logic [COUNT_WIDTH-1:0] cand_inc     [NUM_LETTERS];
   logic [TOTAL_WIDTH-1:0] pool_total_ff;
   logic [TOTAL_WIDTH-1:0] pool_total_in;
   logic [TOTAL_WIDTH-1:0] pool_base;
   logic [TOTAL_WIDTH-1:0] cand_total_ff;
   logic [TOTAL_WIDTH-1:0] cand_total_in;
   logic [TOTAL_WIDTH-1:0] cand_total_inc;
   logic                   pool_open_ff;
   logic                   pool_open_in;
   logic [NUM_LETTERS-1:0] fit_vec;
   logic [7:0]             letter_off;
   logic                   counted;
   logic                   is_pool;
   logic                   is_cand;
   logic                   pool_clear;
   logic                   cand_clear;
   logic                   rsp_write;
   rsp_type                rsp_result;
   logic [CNT_W-1:0]       fifo_count;
   logic [CNT_W:0]         occupancy;

   // space is reserved for the item in flight
   assign occupancy = {1'b0, fifo_count} + {{CNT_W{1'b0}}, in_valid_ff};
   assign req_ready = (occupancy < (CNT_W+1)'(RSP_FIFO_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= req_valid && req_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   assign letter_off = in_data_ff.char_code - LOWEST_LETTER;
   assign counted    = (in_data_ff.char_code >= LOWEST_LETTER)
                    && (in_data_ff.char_code <= HIGHEST_LETTER)
                    && (letter_off < 8'(NUM_LETTERS))
                    && (letter_off < 8'(LETTER_SPAN));
   assign is_pool    = in_valid_ff && (in_data_ff.cmd == CMD_POOL);
   assign is_cand    = in_valid_ff && (in_data_ff.cmd == CMD_CANDIDATE);
   assign pool_clear = is_pool && !pool_open_ff;
   assign cand_clear = in_valid_ff && in_data_ff.last_char;
   assign rsp_write  = is_cand && in_data_ff.last_char;

   // per-letter lanes
   for (genvar i = 0; i < NUM_LETTERS; i++) begin : g_lane
      logic                   hit;
      logic [COUNT_WIDTH-1:0] pool_lane_base;

      assign hit            = counted && (letter_off == 8'(i));
      assign pool_lane_base = pool_clear ? '0 : pool_hist_ff[i];
      assign pool_hist_in[i] = pool_lane_base
         + COUNT_WIDTH'(is_pool && hit && !(&pool_lane_base));
      assign cand_inc[i] = cand_hist_ff[i]
         + COUNT_WIDTH'(is_cand && hit && !(&cand_hist_ff[i]));
      assign cand_hist_in[i] = cand_clear ? '0 : cand_inc[i];
      assign fit_vec[i]      = (cand_inc[i] <= pool_hist_ff[i]);

      always_ff @(posedge clock) begin
         if (reset) begin
            pool_hist_ff[i] <= '0;
            cand_hist_ff[i] <= '0;
         end else if (in_valid_ff) begin
            pool_hist_ff[i] <= pool_hist_in[i];
            cand_hist_ff[i] <= cand_hist_in[i];
         end
      end
   end

   always_comb begin
      pool_base      = pool_clear ? '0 : pool_total_ff;
      pool_total_in  = pool_base + TOTAL_WIDTH'(is_pool && counted && !(&pool_base));
      cand_total_inc = cand_total_ff
         + TOTAL_WIDTH'(is_cand && counted && !(&cand_total_ff));
      cand_total_in  = cand_clear ? '0 : cand_total_inc;
      pool_open_in   = pool_open_ff;
      if (is_pool) begin
         pool_open_in = !in_data_ff.last_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_total_ff <= '0;
         cand_total_ff <= '0;
         pool_open_ff  <= 1'b1;
      end else if (in_valid_ff) begin
         pool_total_ff <= pool_total_in;
         cand_total_ff <= cand_total_in;
         pool_open_ff  <= pool_open_in;
      end
   end

   assign rsp_result.contained         = &fit_vec;
   assign rsp_result.candidate_letters = cand_total_inc;
   assign rsp_result.pool_letters      = pool_total_ff;

   lmc_result_fifo u_result_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (rsp_write),
      .wr_data  (rsp_result),
      .rd_valid (rsp_valid),
      .rd_ready (rsp_ready),
      .rd_data  (rsp_data),
      .count    (fifo_count)
   );

   a_cand_cleared_after_last: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && in_data_ff.last_char) |=> cand_total_ff == '0)
      else $error("candidate total not cleared after last character");

   a_new_pool_restarts: assert property (@(posedge clock) disable iff (reset)
      pool_clear |=> (pool_total_ff <= TOTAL_WIDTH'(1))
                     && (pool_open_ff == !$past(in_data_ff.last_char)))
      else $error("new pool did not restart its count");

   a_pool_closes_on_last: assert property (@(posedge clock) disable iff (reset)
      $fell(pool_open_ff) |-> $past(is_pool && in_data_ff.last_char))
      else $error("pool closed without a last pool character");

endmodule
